[hw/rtl/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared widths, sizes, codes and helpers of the mesh face dedup table.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int VTX_W      = 12;
  localparam int FACE_W     = 14;
  localparam int FACES      = 16384;
  localparam int TOTAL_W    = 15;
  localparam int LIST_DEPTH = 64;
  localparam int OFF_W      = 6;
  localparam int LEN_W      = 7;
  localparam int CELL_W     = 12;
  localparam int CELL_FACES = 6;
  localparam int SLOT_W     = 3;
  localparam int STAT_W     = 3;
  localparam int CLR_W      = 12;

  typedef logic [VTX_W-1:0]           vtx_t;
  typedef logic [3:0][VTX_W-1:0]      quad_t;
  typedef logic [FACE_W-1:0]          face_t;
  typedef logic [3:0][LEN_W-1:0]      lens_t;

  typedef enum logic [STAT_W-1:0] {
    ST_SKIPPED  = 3'd0,
    ST_NEW      = 3'd1,
    ST_BOUNDARY = 3'd2,
    ST_INTERIOR = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    OP_BOUNDARY = 1'b0,
    OP_CELL     = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LEN, S_LEN_END, S_DECIDE, S_SCAN_L, S_SCAN_F, S_SCAN_C,
    S_NEW, S_MAKE, S_FIN, S_DONE
  } state_t;

  // more than one vertex repeats
  function automatic logic degenerate(quad_t v);
    logic [1:0] rep;
    rep = 2'd0;
    if (v[0] == v[1] || v[0] == v[2] || v[0] == v[3]) rep = rep + 2'd1;
    if (v[1] == v[2] || v[1] == v[3]) rep = rep + 2'd1;
    if (v[2] == v[3]) rep = rep + 2'd1;
    return rep > 2'd1;
  endfunction

  // every vertex list keeps room for all its occurrences
  function automatic logic node_room(quad_t v, lens_t len);
    logic [2:0] cnt;
    logic       ok;
    ok = 1'b1;
    for (int j = 0; j < 4; j++) begin
      cnt = 3'd0;
      for (int k = 0; k < 4; k++) begin
        if (v[k] == v[j]) cnt = cnt + 3'd1;
      end
      if ({1'b0, len[j]} + {5'd0, cnt} > (LEN_W+1)'(LIST_DEPTH)) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

[hw/rtl/mfd_if.sv]
// ----------------------------------------------------------------------------
// mfd_in_if / mfd_out_if
// Valid/ready channels carrying face items in and results out.
// ----------------------------------------------------------------------------
interface mfd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [mfd_pkg::CELL_W-1:0]   cell_index;
  logic [11:0]                  boundary_index;
  logic [mfd_pkg::VTX_W-1:0]    vertex_a;
  logic [mfd_pkg::VTX_W-1:0]    vertex_b;
  logic [mfd_pkg::VTX_W-1:0]    vertex_c;
  logic [mfd_pkg::VTX_W-1:0]    vertex_d;
  modport source (output valid, operation, cell_index, boundary_index,
                  vertex_a, vertex_b, vertex_c, vertex_d, input ready);
  modport sink (input valid, operation, cell_index, boundary_index,
                vertex_a, vertex_b, vertex_c, vertex_d, output ready);
endinterface

interface mfd_out_if;
  logic                         valid;
  logic                         ready;
  logic [mfd_pkg::FACE_W-1:0]   face_index;
  logic [mfd_pkg::STAT_W-1:0]   status;
  logic [mfd_pkg::SLOT_W-1:0]   cell_slot;
  modport source (output valid, face_index, status, cell_slot, input ready);
  modport sink (input valid, face_index, status, cell_slot, output ready);
endinterface

[hw/rtl/mfd_face_match.sv]
// ----------------------------------------------------------------------------
// mfd_face_match
// Checks that all four stored vertices of a face lie in the item's four.
// ----------------------------------------------------------------------------
module mfd_face_match (
  input  mfd_pkg::quad_t stored,
  input  mfd_pkg::quad_t item,
  output logic           match
);

  logic [3:0] hit;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit[k] = stored[k] == item[0] || stored[k] == item[1] ||
               stored[k] == item[2] || stored[k] == item[3];
    end
    match = &hit;
  end

endmodule

[hw/rtl/mesh_face_dedup_table.sv]
// ----------------------------------------------------------------------------
// mesh_face_dedup_table
// Table of unique mesh faces with per-vertex face lists and per-cell counts.
// ----------------------------------------------------------------------------
// Items arrive on in_ch (valid/ready) and give exactly one result on out_ch.
// One item is worked at a time by a sequencer around its memories: the
// four vertex list lengths are read, then each listed face of the first
// vertex is scanned by a list read, a face read and a compare; a new face
// writes one list entry per vertex, and a cell item that finds or makes
// its face then updates its cell count. How long an item takes depends
// mostly on the scan length of the first vertex.
// After reset a clearing pass zeroes all list lengths and cell counts;
// in_ch.ready stays low meanwhile. A finished result sits in the output
// register until taken; the next item is accepted meanwhile and waits at
// its end if the register is still full.
// ----------------------------------------------------------------------------
module mesh_face_dedup_table (
  input  logic          clk,
  input  logic          rst,
  mfd_in_if.sink        in_ch,
  mfd_out_if.source     out_ch
);

  mfd_pkg::state_t state, state_next;

  // item
  logic                          op;
  logic [mfd_pkg::CELL_W-1:0]    cell_id;
  mfd_pkg::quad_t                v;
  mfd_pkg::lens_t                len;

  logic [1:0]                    k;
  logic [mfd_pkg::OFF_W-1:0]     idx;
  logic [mfd_pkg::CLR_W-1:0]     clr;
  logic [mfd_pkg::TOTAL_W-1:0]   face_total;

  mfd_pkg::face_t                res_face;
  mfd_pkg::status_t              res_status;

  // memories
  logic [mfd_pkg::LEN_W-1:0]     node_len  [4096];
  logic [mfd_pkg::FACE_W-1:0]    node_list [262144];
  logic [mfd_pkg::SLOT_W-1:0]    cell_tot  [4096];
  logic [48:0]                   face_mem  [mfd_pkg::FACES];

  logic [mfd_pkg::LEN_W-1:0]     len_rd;
  mfd_pkg::face_t                list_rd;
  logic [mfd_pkg::SLOT_W-1:0]    cell_rd;
  logic [48:0]                   face_rd;

  logic                          match;
  logic                          room;
  logic                          full;
  logic [mfd_pkg::LEN_W-1:0]     off;
  logic [mfd_pkg::LEN_W-1:0]     scan_len;

  mfd_face_match u_match (
    .stored (mfd_pkg::quad_t'(face_rd[47:0])),
    .item   (v),
    .match  (match)
  );

  assign room     = mfd_pkg::node_room(v, len);
  assign full     = face_total[mfd_pkg::TOTAL_W-1];
  assign scan_len = (len[0] > mfd_pkg::LEN_W'(mfd_pkg::LIST_DEPTH)) ?
                    mfd_pkg::LEN_W'(mfd_pkg::LIST_DEPTH) : len[0];

  // list position of occurrence k, counting earlier repeats
  always_comb begin
    off = len[k];
    for (int j = 0; j < 3; j++) begin
      if (j < int'(k) && v[j] == v[k]) off = off + mfd_pkg::LEN_W'(1);
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (state == mfd_pkg::S_CLEAR) begin
      node_len[clr] <= '0;
    end else if (state == mfd_pkg::S_MAKE) begin
      node_len[v[k]] <= off + mfd_pkg::LEN_W'(1);
    end
    len_rd <= node_len[v[k]];
  end

  always_ff @(posedge clk) begin
    if (state == mfd_pkg::S_MAKE) begin
      node_list[{v[k], off[mfd_pkg::OFF_W-1:0]}] <= face_total[mfd_pkg::FACE_W-1:0];
    end
    if (state == mfd_pkg::S_SCAN_L) begin
      list_rd <= node_list[{v[0], idx}];
    end
  end

  // count is read during the length reads and held for the slot
  always_ff @(posedge clk) begin
    if (state == mfd_pkg::S_CLEAR) begin
      cell_tot[clr] <= '0;
    end else if (state == mfd_pkg::S_FIN) begin
      cell_tot[cell_id] <= cell_rd + mfd_pkg::SLOT_W'(1);
    end
    if (state == mfd_pkg::S_LEN) begin
      cell_rd <= cell_tot[cell_id];
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfd_pkg::S_MAKE && k == 2'd0) begin
      face_mem[face_total[mfd_pkg::FACE_W-1:0]] <= {op == mfd_pkg::OP_BOUNDARY, v};
    end
    if (state == mfd_pkg::S_SCAN_F) begin
      face_rd <= face_mem[list_rd];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mfd_pkg::S_CLEAR: begin
        if (clr == '1) state_next = mfd_pkg::S_IDLE;
      end
      mfd_pkg::S_IDLE: begin
        if (in_ch.valid) state_next = mfd_pkg::S_LEN;
      end
      mfd_pkg::S_LEN: begin
        if (k == 2'd3) state_next = mfd_pkg::S_LEN_END;
      end
      mfd_pkg::S_LEN_END: state_next = mfd_pkg::S_DECIDE;
      mfd_pkg::S_DECIDE: begin
        priority if (op == mfd_pkg::OP_BOUNDARY) state_next = mfd_pkg::S_NEW;
        else if (mfd_pkg::degenerate(v)) state_next = mfd_pkg::S_DONE;
        else if (cell_rd >= mfd_pkg::SLOT_W'(mfd_pkg::CELL_FACES))
          state_next = mfd_pkg::S_DONE;
        else if (scan_len == '0) state_next = mfd_pkg::S_NEW;
        else state_next = mfd_pkg::S_SCAN_L;
      end
      mfd_pkg::S_SCAN_L: state_next = mfd_pkg::S_SCAN_F;
      mfd_pkg::S_SCAN_F: state_next = mfd_pkg::S_SCAN_C;
      mfd_pkg::S_SCAN_C: begin
        priority if (match) state_next = mfd_pkg::S_FIN;
        else if ({1'b0, idx} + mfd_pkg::LEN_W'(1) == scan_len) state_next = mfd_pkg::S_NEW;
        else state_next = mfd_pkg::S_SCAN_L;
      end
      mfd_pkg::S_NEW: begin
        if (!full && room) state_next = mfd_pkg::S_MAKE;
        else state_next = mfd_pkg::S_DONE;
      end
      mfd_pkg::S_MAKE: begin
        if (k == 2'd3) begin
          state_next = (op == mfd_pkg::OP_CELL) ? mfd_pkg::S_FIN : mfd_pkg::S_DONE;
        end
      end
      mfd_pkg::S_FIN: state_next = mfd_pkg::S_DONE;
      mfd_pkg::S_DONE: begin
        if (!out_ch.valid || out_ch.ready) state_next = mfd_pkg::S_IDLE;
      end
      default: state_next = mfd_pkg::S_CLEAR;
    endcase
  end

  assign in_ch.ready = state == mfd_pkg::S_IDLE;

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      k          <= '0;
      face_total <= '0;
    end else begin
      unique case (state)
        mfd_pkg::S_CLEAR: clr <= clr + mfd_pkg::CLR_W'(1);
        mfd_pkg::S_IDLE: begin
          k <= '0;
          if (in_ch.valid) begin
            op      <= in_ch.operation;
            cell_id <= in_ch.cell_index;
            v       <= {in_ch.vertex_d, in_ch.vertex_c, in_ch.vertex_b, in_ch.vertex_a};
          end
        end
        mfd_pkg::S_LEN: begin
          if (k != 2'd0) len[k - 2'd1] <= len_rd;
          k <= k + 2'd1;
        end
        mfd_pkg::S_LEN_END: len[3] <= len_rd;
        mfd_pkg::S_DECIDE: begin
          idx        <= '0;
          res_face   <= '0;
          res_status <= mfd_pkg::degenerate(v) && op == mfd_pkg::OP_CELL ?
                        mfd_pkg::ST_SKIPPED : mfd_pkg::ST_OVERFLOW;
        end
        mfd_pkg::S_SCAN_C: begin
          idx <= idx + mfd_pkg::OFF_W'(1);
          if (match) begin
            res_face   <= list_rd;
            res_status <= face_rd[48] ? mfd_pkg::ST_BOUNDARY : mfd_pkg::ST_INTERIOR;
          end
        end
        mfd_pkg::S_NEW: begin
          k <= '0;
          if (!full && room) begin
            res_face   <= face_total[mfd_pkg::FACE_W-1:0];
            res_status <= mfd_pkg::ST_NEW;
          end
        end
        mfd_pkg::S_MAKE: begin
          k <= k + 2'd1;
          if (k == 2'd3) face_total <= face_total + mfd_pkg::TOTAL_W'(1);
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (state == mfd_pkg::S_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        out_ch.status <= res_status;
        if (res_status == mfd_pkg::ST_OVERFLOW || res_status == mfd_pkg::ST_SKIPPED) begin
          out_ch.face_index <= '0;
          out_ch.cell_slot  <= '0;
        end else begin
          out_ch.face_index <= res_face;
          out_ch.cell_slot  <= (op == mfd_pkg::OP_CELL) ? cell_rd : '0;
        end
      end
    end
  end

  // ---------------- assertions ----------------
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == mfd_pkg::S_CLEAR |-> !in_ch.ready)
    else $error("item accepted during clearing pass");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (state == mfd_pkg::S_MAKE && k == 2'd3) |=>
      face_total == $past(face_total) + mfd_pkg::TOTAL_W'(1))
    else $error("face total did not advance after a new face");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == mfd_pkg::S_SCAN_L |-> {1'b0, idx} < scan_len)
    else $error("scan past end of vertex list");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == mfd_pkg::ST_OVERFLOW ||
                      out_ch.status == mfd_pkg::ST_SKIPPED)) |->
      (out_ch.face_index == '0 && out_ch.cell_slot == '0))
    else $error("nonzero fields on skipped or overflow result");

endmodule

[test/mesh_face_dedup_table_tb.sv]
// ----------------------------------------------------------------------------
// mesh_face_dedup_table_tb
// Drives boundary and cell face items into the dedup table, tracks the face
// table, vertex lists and cell counts alongside it, and checks every result.
// ----------------------------------------------------------------------------
module mesh_face_dedup_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VERTEX_COUNT = 4096;
  localparam int CELL_COUNT   = 4096;
  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT   = 20000;
  localparam logic signed [12:0] NO_CELL      = -13'sd10;
  localparam logic signed [12:0] INTERIOR_TAG = -13'sd10;

  typedef struct packed {
    mfd_pkg::op_t                op;
    logic [mfd_pkg::CELL_W-1:0]  cell_id;
    logic [11:0]                 bnd;
    mfd_pkg::quad_t              v;
  } face_item_t;

  typedef struct packed {
    mfd_pkg::face_t              face;
    mfd_pkg::status_t            status;
    logic [mfd_pkg::SLOT_W-1:0]  slot;
  } face_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mfd_in_if  in_ch ();
  mfd_out_if out_ch ();

  mesh_face_dedup_table DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // shadow of the face table
  mfd_pkg::quad_t             face_vtx [mfd_pkg::FACES];
  logic [mfd_pkg::CELL_W-1:0] face_first [mfd_pkg::FACES];
  logic signed [12:0]         face_second [mfd_pkg::FACES];
  logic signed [12:0]         face_tag [mfd_pkg::FACES];
  int                face_count;
  int                vtx_len [VERTEX_COUNT];
  int                vtx_list [VERTEX_COUNT*mfd_pkg::LIST_DEPTH];
  int                cell_len [CELL_COUNT];

  face_item_t     pending_items [$];
  face_result_t   expected_results [$];
  mfd_pkg::quad_t known_quads [$];
  int           errors = 0;
  int           accepted_results = 0;
  logic         stimulus_done = 1'b0;

  function automatic bit has_vertex(mfd_pkg::vtx_t x, mfd_pkg::quad_t v);
    return x == v[0] || x == v[1] || x == v[2] || x == v[3];
  endfunction

  function automatic bit lists_have_room(mfd_pkg::quad_t v);
    int cnt;
    for (int j = 0; j < 4; j++) begin
      cnt = 0;
      for (int k = 0; k < 4; k++) if (v[k] == v[j]) cnt++;
      if (vtx_len[v[j]] + cnt > mfd_pkg::LIST_DEPTH) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int add_face(mfd_pkg::quad_t v, logic [mfd_pkg::CELL_W-1:0] cell_id,
                                  logic signed [12:0] tag);
    int f;
    f = face_count;
    for (int k = 0; k < 4; k++) begin
      vtx_list[v[k]*mfd_pkg::LIST_DEPTH + vtx_len[v[k]]] = f;
      vtx_len[v[k]]++;
    end
    face_vtx[f]    = v;
    face_first[f]  = cell_id;
    face_second[f] = NO_CELL;
    face_tag[f]    = tag;
    face_count     = f + 1;
    return f;
  endfunction

  function automatic face_result_t dedup_face(face_item_t it);
    face_result_t r;
    int  rep, f, fid;
    bit  found;
    r = '{face: '0, status: mfd_pkg::ST_OVERFLOW, slot: '0};
    if (it.op == mfd_pkg::OP_BOUNDARY) begin
      if (face_count < mfd_pkg::FACES && lists_have_room(it.v)) begin
        r.face   = mfd_pkg::face_t'(add_face(it.v, '0, $signed({1'b0, it.bnd})));
        r.status = mfd_pkg::ST_NEW;
      end
    end else begin
      rep = 0;
      if (it.v[0] == it.v[1] || it.v[0] == it.v[2] || it.v[0] == it.v[3]) rep++;
      if (it.v[1] == it.v[2] || it.v[1] == it.v[3]) rep++;
      if (it.v[2] == it.v[3]) rep++;
      if (rep > 1) begin
        r.status = mfd_pkg::ST_SKIPPED;
      end else if (cell_len[it.cell_id] < mfd_pkg::CELL_FACES) begin
        found = 1'b0;
        fid = 0;
        for (int i = 0; i < vtx_len[it.v[0]] && !found; i++) begin
          f = vtx_list[it.v[0]*mfd_pkg::LIST_DEPTH + i];
          if (has_vertex(face_vtx[f][0], it.v) && has_vertex(face_vtx[f][1], it.v) &&
              has_vertex(face_vtx[f][2], it.v) && has_vertex(face_vtx[f][3], it.v)) begin
            found = 1'b1;
            fid = f;
          end
        end
        if (found) begin
          if (face_tag[fid] >= 0) begin
            face_first[fid] = it.cell_id;
            r.status = mfd_pkg::ST_BOUNDARY;
          end else begin
            face_second[fid] = $signed({1'b0, it.cell_id});
            r.status = mfd_pkg::ST_INTERIOR;
          end
          r.face = mfd_pkg::face_t'(fid);
        end else if (face_count < mfd_pkg::FACES && lists_have_room(it.v)) begin
          r.face   = mfd_pkg::face_t'(add_face(it.v, it.cell_id, INTERIOR_TAG));
          r.status = mfd_pkg::ST_NEW;
        end
        if (r.status != mfd_pkg::ST_OVERFLOW) begin
          r.slot = mfd_pkg::SLOT_W'(cell_len[it.cell_id]);
          cell_len[it.cell_id]++;
        end
      end
    end
    if (r.status == mfd_pkg::ST_OVERFLOW || r.status == mfd_pkg::ST_SKIPPED) begin
      r.face = '0;
      r.slot = '0;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_item(mfd_pkg::op_t op, int cell_id, int bnd,
                            int a, int b, int c, int d);
    face_item_t it;
    it.op      = op;
    it.cell_id = mfd_pkg::CELL_W'(cell_id);
    it.bnd     = 12'(bnd);
    it.v       = {mfd_pkg::VTX_W'(d), mfd_pkg::VTX_W'(c), mfd_pkg::VTX_W'(b),
                  mfd_pkg::VTX_W'(a)};
    pending_items.push_back(it);
  endtask

  // sender
  int  send_gap = 0;
  bit  send_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(dedup_face(pending_items.pop_front()));
        send_gap = send_calm ? 0 : draw_gap();
        if ($urandom_range(0, 199) == 0) send_calm = ~send_calm;
      end
      if ((!in_ch.valid || in_ch.ready) && (send_gap > 0 || pending_items.size() == 0)) begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end else if (!in_ch.valid || in_ch.ready) begin
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= pending_items[0].op;
        in_ch.cell_index     <= pending_items[0].cell_id;
        in_ch.boundary_index <= pending_items[0].bnd;
        in_ch.vertex_a       <= pending_items[0].v[0];
        in_ch.vertex_b       <= pending_items[0].v[1];
        in_ch.vertex_c       <= pending_items[0].v[2];
        in_ch.vertex_d       <= pending_items[0].v[3];
      end
    end
  end

  // receiver with one long hold-off
  int  take_gap = 0;
  bit  held_off = 1'b0;
  always @(posedge clk) begin
    face_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        accepted_results++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: face_index %0d status %0d",
                 out_ch.face_index, out_ch.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.face_index !== want.face) begin
            $error("face_index expected %0d actual %0d", want.face, out_ch.face_index);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.cell_slot !== want.slot) begin
            $error("cell_slot expected %0d actual %0d", want.slot, out_ch.cell_slot);
            errors++;
          end
        end
        take_gap = draw_gap();
        if (!held_off && accepted_results == 300) begin
          held_off = 1'b1;
          take_gap = 600;
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake activity
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("mesh_face_dedup_table test failed");
      $finish;
    end
  end

  initial begin
    mfd_pkg::quad_t q, p;
    int    pick, rot, cell_id, a, b, c, d;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.cell_index = '0;
    in_ch.boundary_index = '0;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    in_ch.vertex_c = '0;
    in_ch.vertex_d = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < VERTEX_COUNT; i++) vtx_len[i] = 0;
    for (int i = 0; i < CELL_COUNT; i++) cell_len[i] = 0;
    face_count = 0;

    // directed part
    queue_item(mfd_pkg::OP_BOUNDARY, 0, 4095, 4095, 0, 4094, 1);
    queue_item(mfd_pkg::OP_CELL, 4095, 0, 1, 4094, 0, 4095);   // matches boundary face
    queue_item(mfd_pkg::OP_CELL, 0, 4095, 10, 11, 12, 12);      // new triangle
    queue_item(mfd_pkg::OP_CELL, 4094, 0, 12, 11, 10, 10);      // interior match
    queue_item(mfd_pkg::OP_CELL, 7, 0, 20, 20, 21, 21);         // degenerate
    queue_item(mfd_pkg::OP_CELL, 7, 0, 4095, 4095, 4095, 4095); // degenerate
    queue_item(mfd_pkg::OP_BOUNDARY, 0, 0, 0, 0, 0, 0);         // repeats, no check
    for (int i = 0; i < 7; i++)                                 // cell list fills
      queue_item(mfd_pkg::OP_CELL, 4095, 0, 100 + i, 200, 300, 400 + i);
    for (int i = 0; i < 17; i++)                                // vertex list fills
      queue_item(mfd_pkg::OP_BOUNDARY, 0, i, 5, 5, 5, 5);
    queue_item(mfd_pkg::OP_CELL, 9, 0, 5, 6, 7, 8);

    // random part over a small vertex pool so faces get shared
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cell_id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
      pick = $urandom_range(0, 99);
      if (pick < 45 && known_quads.size() > 0) begin
        q = known_quads[$urandom_range(0, known_quads.size() - 1)];
        rot = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) p[k] = q[(k + rot) % 4];
        if ($urandom_range(0, 1)) p = {p[0], p[1], p[2], p[3]};
        queue_item(mfd_pkg::OP_CELL, cell_id, 0, p[0], p[1], p[2], p[3]);
      end else if (pick < 92) begin
        if ($urandom_range(0, 9) == 0) begin
          a = $urandom; b = $urandom; c = $urandom; d = $urandom;
        end else begin
          a = $urandom_range(0, 255); b = $urandom_range(0, 255);
          c = $urandom_range(0, 255);
          d = $urandom_range(0, 3) == 0 ? c : $urandom_range(0, 255);
        end
        q = {mfd_pkg::VTX_W'(d), mfd_pkg::VTX_W'(c), mfd_pkg::VTX_W'(b),
             mfd_pkg::VTX_W'(a)};
        known_quads.push_back(q);
        if (pick < 75)
          queue_item(mfd_pkg::OP_CELL, cell_id, $urandom, a, b, c, d);
        else
          queue_item(mfd_pkg::OP_BOUNDARY, $urandom, $urandom_range(0, 4095), a, b, c, d);
      end else begin
        a = $urandom_range(0, 255);
        queue_item(mfd_pkg::op_t'($urandom_range(0, 1)), cell_id, $urandom, a, a, a,
                   $urandom_range(0, 255));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("mesh_face_dedup_table test passed");
    end else begin
      $display("mesh_face_dedup_table test failed");
    end
    $finish;
  end

endmodule
